@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk, switched off when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/ist_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ist_pkg
// shared types and constants of the interpolation search table
// ---------------------------------------------------------------------------
package ist_pkg;

  localparam int KEY_W   = 16;
  localparam int INDEX_W = 7;
  localparam int POS_W   = 7;
  localparam int LEN_W   = 8;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [INDEX_W-1:0] entry_index;
    logic [KEY_W-1:0]   search_key;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_PROBE,
    ST_COMPARE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_LO,
    ADDR_HI,
    ADDR_PROBE
  } addr_sel_t;

  typedef enum logic [1:0] {
    RES_MISS,
    RES_LO,
    RES_HI,
    RES_PROBE
  } res_sel_t;

  typedef struct packed {
    logic      mem_write;
    logic      start;
    addr_sel_t addr_sel;
    logic      load_klo;
    logic      load_khi;
    logic      div_start;
    logic      div_step;
    logic      load_probe;
    logic      narrow;
    logic      set_result;
    res_sel_t  res_sel;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic span_small;
    logic key_eq_lo;
    logic key_eq_rd;
    logic out_of_range;
    logic ends_equal;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

@@ design/interpolation_search_table.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interpolation_search_table
// sorted key table with interpolation search lookups
// ---------------------------------------------------------------------------
//
//  channel | signals                          | transaction
//  --------+----------------------------------+-------------------------------
//  req     | req_valid, req_stall, req_data   | write an entry or look up a key
//  rsp     | rsp_valid, rsp_stall, rsp_data   | one found flag and position
//  cfg     | cfg_write, cfg_data              | table_length, no handshake
//
//  a write transaction gives no response
//  a lookup repeats probes until the key is found or the range check ends it;
//  each probe is two end reads, a multiply, a one-bit-per-cycle divide and a
//  probe read through the single read port of the key memory
//  req_stall is high from lookup accept until its response is registered
//  a held response does not block writes; reset clears control state only,
//  the key memory is unknown until written
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module interpolation_search_table #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [ist_pkg::LEN_W-1:0] cfg_data,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  ist_pkg::req_t             req_data,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output ist_pkg::rsp_t             rsp_data
);
  import ist_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: idle, end reads, range check, multiply, divide, probe, compare, emit
  ist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_mode  (req_data.mode),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // key memory, bounds, arithmetic and response register
  ist_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // a lookup holds off the next request while it searches
  `ASSERT_NEXT(a_lookup_holds_req, req_valid && !req_stall && req_data.mode == MODE_LOOKUP, req_stall)
  // a miss always reports position zero
  `ASSERT_IMPL(a_miss_pos_zero, rsp_valid && !rsp_data.found, rsp_data.position == '0)
  // a write never produces a response
  `ASSERT_NEXT(a_write_silent, req_valid && !req_stall && req_data.mode == MODE_WRITE && !rsp_valid, !rsp_valid)

endmodule

@@ design/ist_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ist_ctrl
// sequencer for table writes and the interpolation search probe loop
// ---------------------------------------------------------------------------
module ist_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_mode,
  output logic          req_stall,
  input  ist_pkg::stat_t stat,
  output ist_pkg::cmd_t  cmd
);
  import ist_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.addr_sel = ADDR_LO;
    cmd.res_sel  = RES_MISS;
    req_stall    = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          if (req_mode == MODE_LOOKUP) begin
            cmd.start  = 1'b1;
            state_next = ST_RD_LO;
          end else begin
            cmd.mem_write = 1'b1;
          end
        end
      end
      ST_RD_LO: begin
        cmd.addr_sel = ADDR_LO;
        state_next   = ST_RD_HI;
      end
      ST_RD_HI: begin
        cmd.addr_sel = ADDR_HI;
        cmd.load_klo = 1'b1;
        state_next   = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.load_khi = 1'b1;
        if (stat.span_small) begin
          // final pass: low end first, then high end
          cmd.set_result = 1'b1;
          if (stat.key_eq_lo) begin
            cmd.res_sel = RES_LO;
          end else if (stat.key_eq_rd) begin
            cmd.res_sel = RES_HI;
          end else begin
            cmd.res_sel = RES_MISS;
          end
          state_next = ST_EMIT;
        end else if (stat.out_of_range) begin
          cmd.set_result = 1'b1;
          cmd.res_sel    = RES_MISS;
          state_next     = ST_EMIT;
        end else if (stat.ends_equal) begin
          cmd.set_result = 1'b1;
          cmd.res_sel    = RES_LO;
          state_next     = ST_EMIT;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd.addr_sel   = ADDR_PROBE;
        cmd.load_probe = 1'b1;
        state_next     = ST_COMPARE;
      end
      ST_COMPARE: begin
        if (stat.key_eq_rd) begin
          cmd.set_result = 1'b1;
          cmd.res_sel    = RES_PROBE;
          state_next     = ST_EMIT;
        end else begin
          cmd.narrow = 1'b1;
          state_next = ST_RD_LO;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/ist_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ist_datapath
// key memory, search bounds, multiplier, radix-2 divider and result register
// ---------------------------------------------------------------------------
module ist_datapath #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [ist_pkg::LEN_W-1:0]   cfg_data,
  input  ist_pkg::req_t               req_data,
  input  ist_pkg::cmd_t               cmd,
  output ist_pkg::stat_t              stat,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output ist_pkg::rsp_t               rsp_data
);
  import ist_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int NUM_W  = KEY_W + IDX_W;
  localparam int CNT_W  = $clog2(IDX_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(IDX_W - 1);

  logic [KEY_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rdata;
  logic [IDX_W-1:0] raddr;

  logic [LEN_W-1:0] table_length;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] klo;
  logic [KEY_W-1:0] khi;
  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic [IDX_W-1:0] probe;
  logic [KEY_W-1:0] divisor;
  logic [KEY_W-1:0] rem;
  logic [IDX_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             res_found;
  logic [IDX_W-1:0] res_pos;

  logic [31:0]      widx;
  logic             widx_ok;
  logic [31:0]      len_ext;
  logic [31:0]      used_len;
  logic [IDX_W-1:0] hi_init;
  logic [NUM_W-1:0] product;
  logic [KEY_W:0]   trial;
  logic             trial_ge;
  logic [KEY_W:0]   trial_diff;
  logic [IDX_W:0]   quo_shift;
  logic [IDX_W-1:0] probe_sum;
  logic [IDX_W-1:0] probe_clamped;
  logic [31:0]      pos_ext;

  // write address, ignored beyond the depth
  assign widx    = 32'(req_data.entry_index);
  assign widx_ok = widx < TABLE_DEPTH;

  // length in use, saturated to 2 .. depth
  assign len_ext  = 32'(table_length);
  assign used_len = (len_ext < 32'd2) ? 32'd2 :
                    (len_ext > TABLE_DEPTH) ? TABLE_DEPTH : len_ext;
  assign hi_init  = IDX_W'(used_len - 32'd1);

  // probe position with clamp to lo+1 .. hi-1
  assign probe_sum = lo + quo;
  always_comb begin
    if (quo == '0) begin
      probe_clamped = lo + IDX_W'(1);
    end else if (probe_sum >= hi) begin
      probe_clamped = hi - IDX_W'(1);
    end else begin
      probe_clamped = probe_sum;
    end
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_LO:    raddr = lo;
      ADDR_HI:    raddr = hi;
      ADDR_PROBE: raddr = probe_clamped;
      default:    raddr = lo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write && widx_ok) begin
      mem[widx[IDX_W-1:0]] <= req_data.search_key;
    end
    rdata <= mem[raddr];
  end

  // numerator of the interpolation, quotient fits in IDX_W bits
  assign product = NUM_W'(key - klo) * NUM_W'(hi - lo);

  // one restoring step per cycle, remainder stays below the divisor
  assign trial      = {rem, quo[IDX_W-1]};
  assign trial_ge   = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};
  assign quo_shift  = {quo, trial_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= LEN_W'(2);
    end else if (cfg_write) begin
      table_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= req_data.search_key;
      lo  <= '0;
      hi  <= hi_init;
    end else if (cmd.narrow) begin
      if (key < rdata) begin
        hi <= probe;
      end else begin
        lo <= probe;
      end
    end
    if (cmd.load_klo) begin
      klo <= rdata;
    end
    if (cmd.load_khi) begin
      khi <= rdata;
    end
    if (cmd.div_start) begin
      rem     <= product[NUM_W-1:IDX_W];
      quo     <= product[IDX_W-1:0];
      divisor <= khi - klo;
      cnt     <= '0;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? trial_diff[KEY_W-1:0] : trial[KEY_W-1:0];
      quo <= quo_shift[IDX_W-1:0];
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.load_probe) begin
      probe <= probe_clamped;
    end
    if (cmd.set_result) begin
      case (cmd.res_sel)
        RES_LO: begin
          res_found <= 1'b1;
          res_pos   <= lo;
        end
        RES_HI: begin
          res_found <= 1'b1;
          res_pos   <= hi;
        end
        RES_PROBE: begin
          res_found <= 1'b1;
          res_pos   <= probe;
        end
        default: begin
          res_found <= 1'b0;
          res_pos   <= '0;
        end
      endcase
    end
  end

  // output register
  assign pos_ext = 32'(res_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_data.found    <= res_found;
      rsp_data.position <= pos_ext[POS_W-1:0];
    end
  end

  assign stat.span_small   = (hi - lo) <= IDX_W'(1);
  assign stat.key_eq_lo    = key == klo;
  assign stat.key_eq_rd    = key == rdata;
  assign stat.out_of_range = (key < klo) || (key > rdata);
  assign stat.ends_equal   = rdata == klo;
  assign stat.div_last     = cnt == LAST_STEP;
  assign stat.out_free     = !rsp_valid || !rsp_stall;

endmodule
